// ----- rtl/core/ssd_pkg.sv -----
// Shared types and constants of the sequential stream detector.
// Used by ssd_ctrl, ssd_dpath and the top level; depends on nothing.
package ssd_pkg;

    localparam int STREAMS = 16;
    localparam int IDX_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;
    localparam logic [31:0] THRESH_RESET  = 32'd0;
    localparam logic [31:0] AGE_RESET     = 32'd400;
    localparam logic [7:0]  SWEEP_RESET   = 8'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_AGE_LIMIT = 2'd1,
        CFG_SWEEP     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_NEW     = 3'd0,
        KIND_EXTEND  = 3'd1,
        KIND_RESTART = 3'd2,
        KIND_HIT_LOW = 3'd3,
        KIND_DROP    = 3'd4,
        KIND_EVICT   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        RD_SEL  = 2'd0,
        RD_SCAN = 2'd1,
        RD_BEST = 2'd2
    } t_rd_src;

    typedef struct packed {
        logic    latch_in;
        logic    lookup;
        logic    apply;
        logic    scan_clr;
        logic    scan_step;
        logic    evict;
        logic    push;
        logic    push_last;
        t_rd_src rd_src;
    } t_cmd;

    typedef struct packed {
        logic sweep_due;
        logic scan_done;
        logic best_found;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/sequential_stream_detector_unit.sv -----
// Top level of the sequential write stream detector.
// Instantiates ssd_ctrl and ssd_dpath; uses ssd_pkg.
//
// Usage: each input word on the slave stream is one write (address and
// time stamp). For every write the block returns one result word on the
// master stream, followed by one word per tracker evicted in a sweep,
// ordered by ascending stream start; tlast marks the final word of a write.
// Registers (restart threshold, age limit, sweep interval) are written
// through the configuration channel, which is always ready; write them only
// while the block is idle.
// Sequence: a write without a sweep goes from acceptance through lookup over
// the sixteen trackers, update and delivery into the output register; a new
// write is taken only once the last result has been loaded there. A sweep
// walks the table one entry per cycle through the single table read port;
// after each eviction the table is walked anew, and a final walk that finds
// no stale tracker ends the sweep.
// Reset empties the table, clears the event count and loads the default
// registers. When the receiver stalls, the block holds its result word and
// waits; the next write is accepted while the last word is still pending.
module sequential_stream_detector_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // [31:0] lba, [63:32] time_stamp
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // [31:0] stream_start, [63:32] run_offset,
                                      // [95:64] times_repeated, [127:96] seen_time
    output logic [2:0]   o_m_tuser,   // [2:0] kind
    output logic         o_m_tlast,   // is_last
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    ssd_pkg::t_cmd  cmd;
    ssd_pkg::t_stat stat;

    // Registers are plain flops, so a write is taken in any cycle.
    assign o_cfg_ready = 1'b1;

    ssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_lba            (i_s_tdata[31:0]),
        .i_time_stamp     (i_s_tdata[63:32]),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_m_tvalid),
        .i_out_ready      (i_m_tready),
        .o_kind           (o_m_tuser),
        .o_stream_start   (o_m_tdata[31:0]),
        .o_run_offset     (o_m_tdata[63:32]),
        .o_times_repeated (o_m_tdata[95:64]),
        .o_seen_time      (o_m_tdata[127:96]),
        .o_is_last        (o_m_tlast)
    );

endmodule

// ----- rtl/core/ssd_ctrl.sv -----
// Sequencer of the sequential stream detector: steps one write through
// lookup, update, optional eviction sweep and result delivery. Uses ssd_pkg.
module ssd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ssd_pkg::t_stat i_stat,
    output ssd_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOKUP = 6'b000010,
        ST_APPLY  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_EVICT  = 6'b010000,
        ST_FINAL  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_src = ssd_pkg::RD_SEL;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_stat.sweep_due) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_SCAN;
                end else begin
                    n_state = ST_FINAL;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_src    = ssd_pkg::RD_SCAN;
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_EVICT;
                end
            end
            ST_EVICT: begin
                o_cmd.rd_src = ssd_pkg::RD_BEST;
                if (!i_stat.best_found) begin
                    n_state = ST_FINAL;
                end else if (i_stat.out_free) begin
                    // The pending word goes out and the evicted entry takes its place.
                    o_cmd.push     = 1'b1;
                    o_cmd.evict    = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ssd_dpath.sv -----
// Datapath of the sequential stream detector: tracker table, match logic,
// eviction scan, pending result and output register. Uses ssd_pkg.
module ssd_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ssd_pkg::t_cmd  i_cmd,
    output ssd_pkg::t_stat o_stat,
    input  logic [31:0]    i_lba,
    input  logic [31:0]    i_time_stamp,
    input  logic           i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_kind,
    output logic [31:0]    o_stream_start,
    output logic [31:0]    o_run_offset,
    output logic [31:0]    o_times_repeated,
    output logic [31:0]    o_seen_time,
    output logic           o_is_last
);

    localparam int S = ssd_pkg::STREAMS;
    localparam int W = ssd_pkg::IDX_W;

    // Configuration registers.
    logic [31:0] r_thresh, r_age;
    logic [7:0]  r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= ssd_pkg::THRESH_RESET;
            r_age      <= ssd_pkg::AGE_RESET;
            r_interval <= ssd_pkg::SWEEP_RESET;
        end else if (i_cfg_we) begin
            case (ssd_pkg::t_cfg_idx'(i_cfg_index))
                ssd_pkg::CFG_THRESHOLD: r_thresh   <= i_cfg_data;
                ssd_pkg::CFG_AGE_LIMIT: r_age      <= i_cfg_data;
                ssd_pkg::CFG_SWEEP:     r_interval <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Tracker table. r_exp caches start + run, the address each tracker expects next.
    logic [S-1:0] r_valid, r_ext;
    logic [31:0]  r_start [S];
    logic [31:0]  r_run   [S];
    logic [31:0]  r_seen  [S];
    logic [31:0]  r_rep   [S];
    logic [31:0]  r_exp   [S];

    logic [31:0]  r_lba, r_now;
    logic [W-1:0] r_sel, r_scan, r_best;
    ssd_pkg::t_kind r_act;
    logic         r_best_found;
    logic [31:0]  r_best_start;
    logic [7:0]   r_evt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_lba <= i_lba;
            r_now <= i_time_stamp;
        end
    end

    // Single read port of the table.
    logic [W-1:0] rd_addr;
    logic         rd_valid;
    logic [31:0]  rd_start, rd_run, rd_seen, rd_rep;

    always_comb begin
        case (i_cmd.rd_src)
            ssd_pkg::RD_SCAN: rd_addr = r_scan;
            ssd_pkg::RD_BEST: rd_addr = r_best;
            default:          rd_addr = r_sel;
        endcase
        rd_valid = r_valid[rd_addr];
        rd_start = r_start[rd_addr];
        rd_run   = r_run[rd_addr];
        rd_seen  = r_seen[rd_addr];
        rd_rep   = r_rep[rd_addr];
    end

    // Lookup: first start hit, first extendable match, first free slot.
    logic         hit_f, ext_f, free_f;
    logic [W-1:0] hit_i, ext_i, free_i;

    always_comb begin
        hit_f = 1'b0; ext_f = 1'b0; free_f = 1'b0;
        hit_i = '0;   ext_i = '0;   free_i = '0;
        for (int i = 0; i < S; i++) begin
            if (!r_valid[i]) begin
                if (!free_f) begin
                    free_f = 1'b1;
                    free_i = W'(i);
                end
            end else begin
                if (!hit_f && r_start[i] == r_lba) begin
                    hit_f = 1'b1;
                    hit_i = W'(i);
                end
                if (!ext_f && r_ext[i] && r_exp[i] == r_lba) begin
                    ext_f = 1'b1;
                    ext_i = W'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            if (hit_f) begin
                r_act <= ssd_pkg::KIND_RESTART;
                r_sel <= hit_i;
            end else if (ext_f) begin
                r_act <= ssd_pkg::KIND_EXTEND;
                r_sel <= ext_i;
            end else if (free_f) begin
                r_act <= ssd_pkg::KIND_NEW;
                r_sel <= free_i;
            end else begin
                r_act <= ssd_pkg::KIND_DROP;
                r_sel <= '0;
            end
        end
    end

    // Update of the selected tracker.
    logic        hit_low, run_sat, do_write;
    logic [31:0] lba_inc, wr_start, wr_run, wr_seen, wr_rep, claim_addr;
    ssd_pkg::t_kind wr_kind;

    always_comb begin
        hit_low    = rd_run < r_thresh;
        run_sat    = rd_run == ssd_pkg::SAT32;
        lba_inc    = r_lba + 32'd1;
        wr_start   = rd_start;
        wr_run     = rd_run;
        wr_seen    = r_now;
        wr_rep     = rd_rep;
        claim_addr = lba_inc;
        do_write   = 1'b1;
        wr_kind    = r_act;
        case (r_act)
            ssd_pkg::KIND_RESTART: begin
                if (hit_low) begin
                    wr_kind  = ssd_pkg::KIND_HIT_LOW;
                    wr_seen  = rd_seen;
                    do_write = 1'b0;
                end else begin
                    wr_run = 32'd1;
                    wr_rep = (rd_rep == ssd_pkg::SAT32) ? rd_rep : rd_rep + 32'd1;
                end
            end
            ssd_pkg::KIND_EXTEND: begin
                // A saturated run keeps its expected address.
                wr_run     = run_sat ? rd_run : rd_run + 32'd1;
                claim_addr = run_sat ? r_lba : lba_inc;
            end
            ssd_pkg::KIND_NEW: begin
                wr_start = r_lba;
                wr_run   = 32'd1;
                wr_rep   = '0;
            end
            default: begin
                wr_start = r_lba;
                wr_run   = '0;
                wr_rep   = '0;
                do_write = 1'b0;
            end
        endcase
    end

    // Eviction scan: staleness is tested per entry visited; the lowest start wins.
    logic stale;
    assign stale = rd_valid &&
        (({1'b0, rd_seen} + {1'b0, r_age}) < {1'b0, r_now});

    logic [7:0] evt_inc;
    assign evt_inc = r_evt + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_ext        <= '0;
            r_evt        <= '0;
            r_best_found <= 1'b0;
            r_scan       <= '0;
        end else begin
            if (i_cmd.apply) begin
                r_evt <= (evt_inc >= r_interval) ? 8'd0 : evt_inc;
                if (do_write) begin
                    for (int i = 0; i < S; i++) begin
                        if (W'(i) != r_sel && r_valid[i] && r_ext[i] && r_exp[i] == claim_addr)
                            r_ext[i] <= 1'b0;
                    end
                    r_valid[r_sel] <= 1'b1;
                    r_ext[r_sel]   <= 1'b1;
                end
            end
            if (i_cmd.evict) begin
                r_valid[r_best] <= 1'b0;
                r_ext[r_best]   <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_scan       <= '0;
                r_best_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + W'(1);
                if (stale && (!r_best_found || rd_start < r_best_start)) begin
                    r_best_found <= 1'b1;
                    r_best       <= r_scan;
                    r_best_start <= rd_start;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && do_write) begin
            r_start[r_sel] <= wr_start;
            r_run[r_sel]   <= wr_run;
            r_seen[r_sel]  <= wr_seen;
            r_rep[r_sel]   <= wr_rep;
            r_exp[r_sel]   <= claim_addr;
        end
    end

    // Pending result, held until it is known whether it is the last one.
    ssd_pkg::t_kind r_p_kind;
    logic [31:0]    r_p_start, r_p_run, r_p_rep, r_p_seen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_p_kind  <= wr_kind;
            r_p_start <= wr_start;
            r_p_run   <= wr_run;
            r_p_rep   <= wr_rep;
            r_p_seen  <= wr_seen;
        end else if (i_cmd.evict) begin
            r_p_kind  <= ssd_pkg::KIND_EVICT;
            r_p_start <= rd_start;
            r_p_run   <= rd_run;
            r_p_rep   <= rd_rep;
            r_p_seen  <= rd_seen;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_kind           <= r_p_kind;
            o_stream_start   <= r_p_start;
            o_run_offset     <= r_p_run;
            o_times_repeated <= r_p_rep;
            o_seen_time      <= r_p_seen;
            o_is_last        <= i_cmd.push_last;
        end
    end

    assign o_stat.sweep_due  = evt_inc >= r_interval;
    assign o_stat.scan_done  = r_scan == W'(S - 1);
    assign o_stat.best_found = r_best_found;
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!o_out_valid || i_out_ready))
        else $error("result pushed over an untaken word");

    a_best_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_found && !i_cmd.scan_clr && !i_cmd.scan_step) |-> r_valid[r_best])
        else $error("eviction candidate is not a live tracker");

    a_evt_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && o_stat.sweep_due) |=> (r_evt == 8'd0))
        else $error("event count not cleared at sweep");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sequential write stream detector.
// Needs ssd_pkg and sequential_stream_detector_unit; reads nothing else.
// A small scoreboard class predicts each write's result words in order.

typedef struct {
    ssd_pkg::t_kind kind;
    logic [31:0]    start;
    logic [31:0]    run;
    logic [31:0]    repeats;
    logic [31:0]    seen;
    logic           last;
} t_stream_word;

class stream_scoreboard;
    localparam int N = ssd_pkg::STREAMS;

    // Register copies, at their reset values.
    logic [31:0] threshold;
    logic [31:0] age_limit;
    logic [7:0]  sweep_every;

    // Tracker table and event counter.
    bit          live[N];
    bit          owns_next[N];
    logic [31:0] first_lba[N];
    logic [31:0] run_len[N];
    logic [31:0] seen_at[N];
    logic [31:0] restarts[N];
    logic [7:0]  events;

    t_stream_word pending_words[$];
    int errors;

    function new();
        threshold   = ssd_pkg::THRESH_RESET;
        age_limit   = ssd_pkg::AGE_RESET;
        sweep_every = ssd_pkg::SWEEP_RESET;
        events      = 0;
        errors      = 0;
        for (int i = 0; i < N; i++) begin
            live[i]      = 0;
            owns_next[i] = 0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            ssd_pkg::CFG_THRESHOLD: threshold   = value;
            ssd_pkg::CFG_AGE_LIMIT: age_limit   = value;
            ssd_pkg::CFG_SWEEP:     sweep_every = value[7:0];
            default: ;
        endcase
    endfunction

    // Hand the next expected address to one tracker; any other holder loses it.
    function void take_next(int slot, logic [31:0] addr);
        for (int i = 0; i < N; i++)
            if (i != slot && live[i] && owns_next[i] && first_lba[i] + run_len[i] == addr)
                owns_next[i] = 0;
        owns_next[slot] = 1;
    endfunction

    function void push_slot(ssd_pkg::t_kind kind, int i);
        t_stream_word w;
        w.kind = kind; w.start = first_lba[i]; w.run = run_len[i];
        w.repeats = restarts[i]; w.seen = seen_at[i]; w.last = 0;
        pending_words.push_back(w);
    endfunction

    function void note_write(logic [31:0] lba, logic [31:0] now);
        int hit, ext, free_slot, pick;
        bit stale[N];
        t_stream_word w;
        hit = -1; ext = -1; free_slot = -1;
        for (int i = 0; i < N; i++) begin
            if (!live[i]) begin
                if (free_slot < 0) free_slot = i;
            end else begin
                if (hit < 0 && first_lba[i] == lba) hit = i;
                if (ext < 0 && owns_next[i] && first_lba[i] + run_len[i] == lba) ext = i;
            end
        end

        if (hit >= 0) begin
            if (run_len[hit] < threshold) begin
                push_slot(ssd_pkg::KIND_HIT_LOW, hit);
            end else begin
                if (restarts[hit] != ssd_pkg::SAT32) restarts[hit]++;
                run_len[hit] = 1;
                seen_at[hit] = now;
                take_next(hit, lba + 32'd1);
                push_slot(ssd_pkg::KIND_RESTART, hit);
            end
        end else if (ext >= 0) begin
            if (run_len[ext] != ssd_pkg::SAT32) run_len[ext]++;
            seen_at[ext] = now;
            take_next(ext, first_lba[ext] + run_len[ext]);
            push_slot(ssd_pkg::KIND_EXTEND, ext);
        end else if (free_slot >= 0) begin
            live[free_slot]      = 1;
            first_lba[free_slot] = lba;
            run_len[free_slot]   = 1;
            seen_at[free_slot]   = now;
            restarts[free_slot]  = 0;
            take_next(free_slot, lba + 32'd1);
            push_slot(ssd_pkg::KIND_NEW, free_slot);
        end else begin
            w.kind = ssd_pkg::KIND_DROP; w.start = lba; w.run = 0;
            w.repeats = 0; w.seen = now; w.last = 0;
            pending_words.push_back(w);
        end

        // Sweep: evict stale trackers in ascending order of start address.
        events = events + 8'd1;
        if (events >= sweep_every) begin
            events = 0;
            for (int i = 0; i < N; i++)
                stale[i] = live[i] && ({1'b0, seen_at[i]} + {1'b0, age_limit} < {1'b0, now});
            forever begin
                pick = -1;
                for (int i = 0; i < N; i++)
                    if (stale[i] && (pick < 0 || first_lba[i] < first_lba[pick])) pick = i;
                if (pick < 0) break;
                push_slot(ssd_pkg::KIND_EVICT, pick);
                stale[pick]     = 0;
                live[pick]      = 0;
                owns_next[pick] = 0;
            end
        end
        pending_words[pending_words.size() - 1].last = 1;
    endfunction

    task report(string what);
        $display("ERROR %s", what);
        errors++;
    endtask

    task check_result(logic [2:0] kind, logic [127:0] data, logic last);
        t_stream_word w;
        if (pending_words.size() == 0) begin
            report($sformatf("unexpected word kind=%0d data=%h", kind, data));
        end else begin
            w = pending_words.pop_front();
            if (kind !== w.kind)
                report($sformatf("kind %0d, expected %0d", kind, w.kind));
            if (data[31:0] !== w.start)
                report($sformatf("stream_start %h, expected %h", data[31:0], w.start));
            if (data[63:32] !== w.run)
                report($sformatf("run_offset %h, expected %h", data[63:32], w.run));
            if (data[95:64] !== w.repeats)
                report($sformatf("times_repeated %h, expected %h", data[95:64], w.repeats));
            if (data[127:96] !== w.seen)
                report($sformatf("seen_time %h, expected %h", data[127:96], w.seen));
            if (last !== w.last)
                report($sformatf("tlast %b, expected %b", last, w.last));
        end
    endtask
endclass

module testbench;

    localparam logic [1:0] CFG_BAD_IDX = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata = '0;   // [31:0] lba, [63:32] time_stamp
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [127:0] o_m_tdata;        // [31:0] start, [63:32] run, [95:64] repeats, [127:96] seen
    logic [2:0]   o_m_tuser;        // [2:0] kind
    logic         o_m_tlast;        // is_last
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    sequential_stream_detector_unit u_top (.*);

    stream_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    // Watchdog on the total run length.
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Every word accepted on the master side is checked against the oldest prediction.
    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata, o_m_tlast);

    // Receiver: the stall pattern is drawn at random from three modes; hold_cycles forces a long
    // hold-off so that the block fills up and pushes back on its input.
    int hold_cycles = 0;
    int ready_mode  = 0;
    int mode_cycles = 0;
    always @(negedge i_clk) begin
        if (mode_cycles == 0) begin
            ready_mode  = $urandom_range(0, 2);
            mode_cycles = 64;
        end
        mode_cycles--;
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready = 0;
        end else begin
            case (ready_mode)
                0: i_m_tready = 1;
                1: i_m_tready = $urandom_range(0, 1);
                default: i_m_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Sender state: words go out in bursts separated by random gaps.
    int burst_left = 0;
    logic [31:0] now_ticks = 0;

    task send_write(logic [31:0] lba);
        @(negedge i_clk);
        i_s_tvalid = 1;
        i_s_tdata  = {now_ticks, lba};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_write(lba, now_ticks);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_s_tvalid = 0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Ends a burst so that the last word is not offered again.
    task stop_sender;
        @(negedge i_clk);
        i_s_tvalid = 0;
        burst_left = 0;
    endtask

    task write_cfg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // Wait until every predicted word has come back, then let the block settle.
    task drain;
        stop_sender();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Time advances in small steps with an occasional long silence, and
    // saturates rather than wrapping, so stamps never decrease.
    task advance_time;
        logic [32:0] t;
        t = {1'b0, now_ticks} + (($urandom_range(0, 19) == 0) ? $urandom_range(100, 900)
                                                              : $urandom_range(0, 30));
        now_ticks = t[32] ? 32'hFFFF_FFFF : t[31:0];
    endtask

    // Random traffic: mostly sequential runs on a few live streams with random
    // content, plus restarts, repeated addresses and scattered noise.
    task random_traffic(int count);
        logic [31:0] base[4];
        logic [31:0] offset[4];
        int s, pick;
        for (int k = 0; k < 4; k++) begin
            base[k] = $urandom;
            offset[k] = 0;
        end
        for (int n = 0; n < count; n++) begin
            advance_time();
            s = $urandom_range(0, 3);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_write(base[s] + offset[s]);
                offset[s]++;
            end else if (pick < 67) begin
                send_write(base[s]);
                offset[s] = 1;
            end else if (pick < 75) begin
                send_write(base[s] + offset[s] - 1);
            end else if (pick < 85) begin
                base[s] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 64);
                send_write(base[s]);
                offset[s] = 1;
            end else begin
                send_write($urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed part: new, extend, restart, start hit below threshold,
        // a tracker taking over another's next address, address wrap,
        // a full table and a sweep that evicts everything.
        write_cfg(ssd_pkg::CFG_THRESHOLD, 32'd2);
        write_cfg(ssd_pkg::CFG_AGE_LIMIT, 32'd60);
        write_cfg(ssd_pkg::CFG_SWEEP, 8'd30);
        now_ticks = 0;
        send_write(32'd100);
        send_write(32'd101);
        send_write(32'd100);
        send_write(32'd100);
        now_ticks = 5;
        send_write(32'd50);
        send_write(32'd51);
        send_write(32'd52);
        send_write(32'd52);
        send_write(32'd53);
        send_write(32'hFFFF_FFFF);
        send_write(32'd0);
        send_write(32'd0);
        for (int k = 0; k < 15; k++) begin
            now_ticks = now_ticks + 1;
            send_write(32'd7000 + k * 1000);
        end
        // A long silence: the drops that complete the interval trigger a full eviction.
        now_ticks = now_ticks + 1000;
        for (int k = 0; k < 3; k++) send_write(32'hA5A5_0000 + k * 9);
        drain();

        // Everything restarts, only trackers seen at the current stamp survive, a sweep after every write.
        write_cfg(ssd_pkg::CFG_THRESHOLD, 32'd0);
        write_cfg(ssd_pkg::CFG_AGE_LIMIT, 32'd0);
        write_cfg(ssd_pkg::CFG_SWEEP, 8'd1);
        random_traffic(60);
        drain();

        // No restarts, sweep counter wraps on every write; the receiver stops
        // for a long stretch while writes keep coming.
        write_cfg(ssd_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
        write_cfg(ssd_pkg::CFG_AGE_LIMIT, 32'd200);
        write_cfg(ssd_pkg::CFG_SWEEP, 8'd0);
        hold_cycles = 400;
        random_traffic(60);
        drain();

        // A write to the unused register index must change nothing.
        write_cfg(ssd_pkg::CFG_THRESHOLD, 32'd3);
        write_cfg(ssd_pkg::CFG_AGE_LIMIT, 32'd120);
        write_cfg(ssd_pkg::CFG_SWEEP, 8'd255);
        write_cfg(CFG_BAD_IDX, 32'hFFFF_FFFF);
        random_traffic(30);
        // The sender stops until every predicted word has arrived.
        stop_sender();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        random_traffic(30);
        drain();

        // Stamps near the top of their range; with the largest age limit
        // nothing is ever old enough to go.
        write_cfg(ssd_pkg::CFG_THRESHOLD, 32'd1);
        write_cfg(ssd_pkg::CFG_AGE_LIMIT, 32'hFFFF_FFFF);
        write_cfg(ssd_pkg::CFG_SWEEP, 8'd7);
        now_ticks = 32'hFFFF_F000;
        random_traffic(60);

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
